FILE: sv/csfp_pkg.sv
// Shared types, constants and helpers for the clock-sync frame parser.
`default_nettype none

package csfp_pkg;

    localparam int unsigned FRAME_BYTES = 40;
    localparam int unsigned COUNT_MAX   = 41;
    localparam int unsigned COUNT_W     = 6;
    localparam int unsigned NUM_TIMES   = 3;
    localparam int unsigned TIME_W      = 64;
    localparam int unsigned ID_W        = 32;
    localparam int unsigned SIZE_W      = 16;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned M_DATA_W    = 240;

    // Byte positions inside a frame
    localparam logic [COUNT_W-1:0] POS_VERSION  = 6'd4;
    localparam logic [COUNT_W-1:0] POS_TYPE     = 6'd5;
    localparam logic [COUNT_W-1:0] POS_SIZE_LO  = 6'd7;
    localparam logic [COUNT_W-1:0] POS_ID_FIRST = 6'd8;
    localparam logic [COUNT_W-1:0] POS_RSV      = 6'd12;
    localparam logic [COUNT_W-1:0] POS_TIME     = 6'd16;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HEADER  = 3'd1,
        ST_VERSION = 3'd2,
        ST_TYPE    = 3'd3,
        ST_SIZE    = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROTOCOL_VERSION = 2'd0,
        REG_REQUEST_CODE     = 2'd1,
        REG_RESPONSE_CODE    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] protocol_version;
        logic [7:0] request_code;
        logic [7:0] response_code;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] host_send_time;
        logic [TIME_W-1:0] host_receive_time;
        logic [TIME_W-1:0] client_send_time;
        logic [ID_W-1:0]   request_id;
        logic [7:0]        msg_type;
        status_t           status;
    } result_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0:    b = 8'h53; // S
            2'd1:    b = 8'h43; // C
            2'd2:    b = 8'h4C; // L
            default: b = 8'h4B; // K
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: sv/csfp_in_stage.sv
// Input register for the frame byte stream.
`default_nettype none

module csfp_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tlast,
    input  wire logic              advance,
    output logic                   item_valid,
    output csfp_pkg::in_item_t     item
);

    logic               valid_reg, valid_next;
    csfp_pkg::in_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.data_byte  <= s_tdata;
            item_reg.frame_last <= s_tlast;
        end
    end

endmodule

`default_nettype wire

FILE: sv/csfp_parser.sv
// Frame state and field assembly; forms the result on the last byte.
`default_nettype none

module csfp_parser (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               advance,
    input  wire csfp_pkg::in_item_t item,
    input  wire csfp_pkg::cfg_t     cfg,
    output logic                    res_fire,
    output csfp_pkg::result_t       result
);

    logic [csfp_pkg::COUNT_W-1:0] count_reg, count_next;
    csfp_pkg::status_t            err_reg, err_next;
    logic [7:0]                   type_reg, type_next;
    logic [csfp_pkg::SIZE_W-1:0]  size_reg, size_next;
    logic [csfp_pkg::ID_W-1:0]    id_reg, id_next;
    logic [csfp_pkg::TIME_W-1:0]  time_reg [csfp_pkg::NUM_TIMES];
    logic [csfp_pkg::TIME_W-1:0]  time_next [csfp_pkg::NUM_TIMES];

    logic [7:0]                   b;
    logic [csfp_pkg::COUNT_W-1:0] pos;
    logic                         take;
    csfp_pkg::status_t            status;

    assign b    = item.data_byte;
    assign pos  = count_reg;
    assign take = pos < csfp_pkg::COUNT_W'(csfp_pkg::FRAME_BYTES);

    always_comb begin
        err_next  = err_reg;
        type_next = type_reg;
        size_next = size_reg;
        id_next   = id_reg;
        for (int j = 0; j < csfp_pkg::NUM_TIMES; j++) begin
            time_next[j] = time_reg[j];
        end

        if (take) begin
            if (pos < csfp_pkg::POS_VERSION) begin
                if (b != csfp_pkg::magic_byte(pos[1:0]) && err_reg == csfp_pkg::ST_OK) begin
                    err_next = csfp_pkg::ST_HEADER;
                end
            end else if (pos == csfp_pkg::POS_VERSION) begin
                if (b != cfg.protocol_version && err_reg == csfp_pkg::ST_OK) begin
                    err_next = csfp_pkg::ST_VERSION;
                end
            end else if (pos == csfp_pkg::POS_TYPE) begin
                type_next = b;
                if (b != cfg.request_code && b != cfg.response_code &&
                    err_reg == csfp_pkg::ST_OK) begin
                    err_next = csfp_pkg::ST_TYPE;
                end
            end else if (pos < csfp_pkg::POS_ID_FIRST) begin
                size_next = {size_reg[7:0], b};
                if (pos == csfp_pkg::POS_SIZE_LO &&
                    size_next != csfp_pkg::SIZE_W'(csfp_pkg::FRAME_BYTES) &&
                    err_reg == csfp_pkg::ST_OK) begin
                    err_next = csfp_pkg::ST_SIZE;
                end
            end else if (pos < csfp_pkg::POS_RSV) begin
                id_next = {id_reg[csfp_pkg::ID_W-9:0], b};
            end
            // Each timestamp lane shifts during its own eight byte slots
            for (int j = 0; j < csfp_pkg::NUM_TIMES; j++) begin
                if (pos >= csfp_pkg::POS_TIME + csfp_pkg::COUNT_W'(8 * j) &&
                    pos <  csfp_pkg::POS_TIME + csfp_pkg::COUNT_W'(8 * j + 8)) begin
                    time_next[j] = {time_reg[j][csfp_pkg::TIME_W-9:0], b};
                end
            end
        end

        if (count_reg < csfp_pkg::COUNT_W'(csfp_pkg::COUNT_MAX)) begin
            count_next = count_reg + 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_comb begin
        if (count_next != csfp_pkg::COUNT_W'(csfp_pkg::FRAME_BYTES)) begin
            status = csfp_pkg::ST_HEADER;
        end else begin
            status = err_next;
        end
        result = '0;
        result.status = status;
        if (status == csfp_pkg::ST_OK) begin
            result.msg_type          = type_next;
            result.request_id        = id_next;
            result.client_send_time  = time_next[0];
            result.host_receive_time = time_next[1];
            result.host_send_time    = time_next[2];
        end
    end

    assign res_fire = advance && item.frame_last;

    always_ff @(posedge aclk) begin
        if (!aresetn || res_fire) begin
            count_reg <= '0;
            err_reg   <= csfp_pkg::ST_OK;
            type_reg  <= '0;
            size_reg  <= '0;
            id_reg    <= '0;
            for (int j = 0; j < csfp_pkg::NUM_TIMES; j++) begin
                time_reg[j] <= '0;
            end
        end else if (advance) begin
            count_reg <= count_next;
            err_reg   <= err_next;
            type_reg  <= type_next;
            size_reg  <= size_next;
            id_reg    <= id_next;
            for (int j = 0; j < csfp_pkg::NUM_TIMES; j++) begin
                time_reg[j] <= time_next[j];
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/csfp_out_reg.sv
// Result register on the master side.
`default_nettype none

module csfp_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire csfp_pkg::result_t result,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [csfp_pkg::M_DATA_W-1:0] m_tdata
);

    logic              valid_reg, valid_next;
    csfp_pkg::result_t data_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = csfp_pkg::M_DATA_W'(data_reg);

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

`default_nettype wire

FILE: sv/clock_sync_frame_parser.sv
// Clock-sync frame parser top level.
//
// Slave channel: one frame byte per item on s_tdata, s_tlast on the 40th
// (final) byte. Master channel: one result item per frame, carrying the
// status and the assembled header and timestamp fields; fields read as zero
// when the status is not ok.
// Configuration: cfg_we writes cfg_wdata into the register chosen by
// cfg_index (0 protocol version, 1 request code, 2 response code); write
// only while no frame is in flight.
// Throughput: one byte per cycle, unless a last byte is held while the result
// slot is occupied. A result appears on m_tvalid once its last byte has left
// the input register and the single-pass decode has loaded the result register.
// Reset: aresetn (synchronous, active low) clears the frame state, empties
// both registers and restores the default register values.
// Stall: a result waiting on m_tready does not block the byte stream; only a
// next last byte holds in the input register until the result slot frees,
// and s_tready drops behind it.
`default_nettype none

module clock_sync_frame_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // frame_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [2:0] status, [10:3] msg_type, [42:11] request_id,
    // [106:43] client_send_time, [170:107] host_receive_time,
    // [234:171] host_send_time, [239:235] zero
    output logic [csfp_pkg::M_DATA_W-1:0] m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [csfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]  cfg_wdata
);

    csfp_pkg::cfg_t     cfg_reg;
    csfp_pkg::in_item_t item;
    csfp_pkg::result_t  result;
    logic               item_valid;
    logic               advance;
    logic               res_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.protocol_version <= 8'd1;
            cfg_reg.request_code     <= 8'd1;
            cfg_reg.response_code    <= 8'd2;
        end else if (cfg_we) begin
            unique case (cfg_index)
                csfp_pkg::REG_PROTOCOL_VERSION: cfg_reg.protocol_version <= cfg_wdata;
                csfp_pkg::REG_REQUEST_CODE:     cfg_reg.request_code     <= cfg_wdata;
                csfp_pkg::REG_RESPONSE_CODE:    cfg_reg.response_code    <= cfg_wdata;
                default: ; // drop writes to unused index
            endcase
        end
    end

    // Hold a last byte while the result slot is still occupied
    assign advance = item_valid && (!item.frame_last || !m_tvalid || m_tready);

    csfp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    csfp_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .item     (item),
        .cfg      (cfg_reg),
        .res_fire (res_fire),
        .result   (result)
    );

    csfp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_fire),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |=> m_tvalid)
        else $error("last byte did not produce a result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while held");

    a_error_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] != csfp_pkg::ST_OK) |-> (m_tdata[239:3] == '0))
        else $error("fields not cleared on error status");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= csfp_pkg::ST_SIZE))
        else $error("status code out of range");

endmodule

`default_nettype wire
